### design/psev_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psev_pkg: shared types and constants
// Opcodes, status codes and the request/response structs between the
// sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package psev_pkg;

	localparam int DATA_W  = 32;
	localparam int OP_W    = 3;
	localparam int ST_W    = 2;
	localparam int DEPTH_W = 7;

	localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
	localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [ST_W-1:0] ST_DIVZERO   = 2'd3;

	typedef struct packed {
		logic            start;
		logic [OP_W-1:0] op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic divzero;
	} alu_rsp_t;

endpackage
`default_nettype wire

### design/psev_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psev_stack: operand stack storage
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module psev_stack #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [ADDR_W-1:0]          waddr,
	input  wire logic [psev_pkg::DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0]          raddr,
	output logic      [psev_pkg::DATA_W-1:0] rdata
);
	import psev_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### design/psev_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psev_alu: shared arithmetic unit
// Add, subtract and multiply into the result register; signed truncating
// divide by a restoring divider, one quotient bit per cycle, then a sign fix.
// ----------------------------------------------------------------------------
module psev_alu (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire psev_pkg::alu_req_t          req,
	input  wire logic [psev_pkg::DATA_W-1:0] lhs,
	input  wire logic [psev_pkg::DATA_W-1:0] rhs,
	output psev_pkg::alu_rsp_t               rsp,
	output logic      [psev_pkg::DATA_W-1:0] result
);
	import psev_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);

	typedef enum logic [2:0] {
		A_IDLE = 3'b001,
		A_DIV  = 3'b010,
		A_FIX  = 3'b100
	} alu_state_t;

	alu_state_t        state_q;
	logic              done_q;
	logic              divz_q;
	logic [DATA_W-1:0] res_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;

	logic [DATA_W-1:0] mag_l;
	logic [DATA_W-1:0] mag_r;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;

	assign mag_l   = lhs[DATA_W-1] ? (~lhs + 1'b1) : lhs;
	assign mag_r   = rhs[DATA_W-1] ? (~rhs + 1'b1) : rhs;
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			divz_q  <= 1'b0;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						if ((req.op == OP_DIV) && (rhs != '0)) begin
							done_q  <= 1'b0;
							divz_q  <= 1'b0;
							state_q <= A_DIV;
						end else begin
							done_q <= 1'b1;
							divz_q <= (req.op == OP_DIV);
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				A_DIV: begin
					done_q <= 1'b0;
					if (cnt_q == '0) begin
						state_q <= A_FIX;
					end
				end
				A_FIX: begin
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				if (req.start) begin
					rem_q <= '0;
					quo_q <= mag_l;
					den_q <= mag_r;
					neg_q <= lhs[DATA_W-1] ^ rhs[DATA_W-1];
					cnt_q <= CNT_W'(DATA_W - 1);
					case (req.op)
						OP_ADD:  res_q <= lhs + rhs;
						OP_SUB:  res_q <= lhs - rhs;
						OP_MUL:  res_q <= lhs * rhs;
						default: res_q <= '0;
					endcase
				end
			end
			A_DIV: begin
				cnt_q <= cnt_q - 1'b1;
				if (!diff[DATA_W]) begin
					rem_q <= diff[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], 1'b0};
				end
			end
			A_FIX: begin
				res_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign rsp.done    = done_q;
	assign rsp.divzero = divz_q;
	assign result      = res_q;

endmodule
`default_nettype wire

### design/postfix_stack_evaluator_unit.sv
// Push or unused opcode pass from acceptance through decode to writeback; add,
// subtract and multiply also pass an issue and a wait state for the shared
// arithmetic unit, where divide runs the one-bit-per-cycle restoring divider.
// One item at a time: in_ready is high only while the sequencer is idle, so
// a new item is taken only once the previous one has been committed.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low) empties the stack at once; stack contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit: RPN evaluator on an operand stack
// Sequencer around the stack memory and the shared arithmetic unit.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_unit #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic        [psev_pkg::OP_W-1:0]    opcode,
	input  wire logic signed [psev_pkg::DATA_W-1:0]  operand_value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed      [psev_pkg::DATA_W-1:0]  top_value,
	output logic             [$clog2(STACK_DEPTH + 1)-1:0] stack_depth,
	output logic             [psev_pkg::ST_W-1:0]    status
);
	import psev_pkg::*;

	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_OPER   = 5'b00100,
		S_WAIT   = 5'b01000,
		S_WB     = 5'b10000
	} seq_state_t;

	seq_state_t        state_q;
	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] top_q;
	logic [DATA_W-1:0] res_q;
	logic              divz_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] top_value_q;
	logic [CNT_W-1:0]  stack_depth_q;
	logic [ST_W-1:0]   status_q;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic [DATA_W-1:0] alu_res;
	logic [DATA_W-1:0] lhs;
	logic [DATA_W-1:0] rhs;
	logic [DATA_W-1:0] mem_rdata;

	logic              is_push;
	logic              is_arith;
	logic              full;
	logic              count_ge2;
	logic [ADDR_W-1:0] lhs_idx;
	logic              commit;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [DATA_W-1:0] wdata;
	logic [CNT_W-1:0]  count_nxt;
	logic [DATA_W-1:0] top_nxt;
	logic [ST_W-1:0]   status_nxt;
	logic [CNT_W-1:0]  count_m2;

	assign is_push   = (op_q == OP_PUSH);
	assign is_arith  = (op_q >= OP_ADD) && (op_q <= OP_DIV);
	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign count_ge2 = (count_q >= CNT_W'(2));
	assign count_m2  = count_q - CNT_W'(2);
	assign lhs_idx   = count_m2[ADDR_W-1:0];
	assign commit    = (state_q == S_WB) && (!out_valid_q || out_ready);

	assign rhs = (count_q != '0) ? top_q : '1;
	assign lhs = count_ge2 ? mem_rdata : '1;

	assign alu_req.start = (state_q == S_OPER);
	assign alu_req.op    = op_q;

	always_comb begin
		we         = 1'b0;
		waddr      = count_q[ADDR_W-1:0];
		wdata      = val_q;
		count_nxt  = count_q;
		status_nxt = ST_OK;
		if (is_push) begin
			if (full) begin
				status_nxt = ST_OVERFLOW;
			end else begin
				we        = commit;
				count_nxt = count_q + CNT_W'(1);
			end
		end else if (is_arith) begin
			we    = commit;
			wdata = res_q;
			if (count_ge2) begin
				waddr     = lhs_idx;
				count_nxt = count_q - CNT_W'(1);
			end else begin
				waddr      = '0;
				count_nxt  = CNT_W'(1);
			end
			if (!count_ge2) begin
				status_nxt = ST_UNDERFLOW;
			end else if (divz_q) begin
				status_nxt = ST_DIVZERO;
			end
		end
		top_nxt = (we || (commit == 1'b0 && is_arith)) ? wdata : top_q;
		if (is_push && !full) begin
			top_nxt = val_q;
		end
	end

	psev_stack #(
		.DEPTH  (STACK_DEPTH),
		.ADDR_W (ADDR_W)
	) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (lhs_idx),
		.rdata (mem_rdata)
	);

	psev_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.lhs    (lhs),
		.rhs    (rhs),
		.rsp    (alu_rsp),
		.result (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= is_arith ? S_OPER : S_WB;
				end
				S_OPER: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (alu_rsp.done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (commit) begin
						count_q <= count_nxt;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= opcode;
			val_q <= operand_value;
		end
		if ((state_q == S_WAIT) && alu_rsp.done) begin
			res_q  <= alu_res;
			divz_q <= alu_rsp.divzero;
		end
		if (commit) begin
			top_q         <= top_nxt;
			top_value_q   <= (count_nxt == '0) ? '1 : top_nxt;
			stack_depth_q <= count_nxt;
			status_q      <= status_nxt;
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign top_value   = top_value_q;
	assign stack_depth = stack_depth_q;
	assign status      = status_q;

	// stack never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// an arithmetic item always leaves at least one entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(commit && is_arith) |=> (count_q != '0))
		else $error("arithmetic item left stack empty");

	// overflow only reported against a full stack
	assert property (@(posedge clk) disable iff (!arst_n)
		(commit && status_nxt == ST_OVERFLOW) |-> full)
		else $error("overflow without full stack");

	// arithmetic unit answers only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (state_q == S_WAIT))
		else $error("arithmetic unit done outside wait");

	// sequencer returns to idle once a result is committed
	assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> !out_valid_q || (state_q == S_IDLE))
		else $error("sequencer not idle after commit");

endmodule
`default_nettype wire
